>>> rtl/deq_pkg.sv
// Shared types, constants and helpers for the double-ended queue with search.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KIND_W = 3;
	localparam int WORD_W = 32;
	localparam int OCC_W = 5;
	localparam int IDX_W = 4;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_FRONT,
		OP_POP_REAR,
		OP_SEARCH,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_ENDS,
		ST_LOAD
	} state_t;

	typedef struct packed {
		op_t                      op;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t                  status;
		logic signed [WORD_W-1:0] front_word;
		logic signed [WORD_W-1:0] rear_word;
		logic [OCC_W-1:0]         occupancy;
		logic [IDX_W-1:0]         match_index;
		logic                     match_found;
	} res_t;

	// Circular pointer addition; both operands are below DEPTH.
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
			input logic [PTR_W-1:0] off);
		logic [PTR_W:0] s;
		s = {1'b0, p} + {1'b0, off};
		if (s >= (PTR_W + 1)'(DEPTH)) begin
			s = s - (PTR_W + 1)'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

>>> rtl/double_ended_queue_with_search_unit.sv
// Top level of the double-ended queue with search.
// Depends on deq_pkg, deq_front, deq_cmdq and deq_back.
`timescale 1ns / 1ps

// A bounded double-ended queue of DEPTH (16) signed 32-bit words. Each
// transaction is one request, taken at a rising edge where start is high and
// busy is low: kind selects push at the front, push at the rear, pop at the
// front, pop at the rear or search, and value carries the word to push or to
// look for. Every request yields exactly one result, shown for a single cycle
// with done high; the receiver cannot stall it, so it must be captured then.
// The result gives the status (ok, pop while empty, push while full), the
// front and rear words after the request (zero when the queue is empty), the
// occupancy, and for a search the position from the front of the first equal
// word with match_found set; a failed search reports position zero with
// match_found clear. A push while full or a pop while empty changes nothing.
// Requests are queued two deep behind busy and carried out one at a time by
// an execution unit around a single store with one write and two read ports.
// A request other than a search passes the idle, execute, ends and load
// states; a search adds a read and a check state per word compared, since the
// store delivers one word per read and the comparison follows the registered
// read. The result is registered at the end of the load state.
// There is no clearing pass after reset: unused cells never reach a result.

module double_ended_queue_with_search_unit
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [WORD_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] front_word,
	output logic signed [WORD_W-1:0] rear_word,
	output logic [OCC_W-1:0]         occupancy,
	output logic [IDX_W-1:0]         match_index,
	output logic                     match_found
);

	// Front end to queue.
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;

	// Queue to execution unit.
	logic q_pop;
	cmd_t q_pop_cmd;
	logic q_empty;

	res_t res;

	deq_front u_front (
		.start (start),
		.busy  (busy),
		.kind  (kind),
		.value (value),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd (q_push_cmd)
	);

	deq_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (q_pop_cmd),
		.empty   (q_empty)
	);

	deq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_cmd  (q_pop_cmd),
		.q_pop  (q_pop),
		.done   (done),
		.res    (res)
	);

	// The result register sits in the execution unit; unpack it onto the ports.
	assign status = res.status;
	assign front_word = res.front_word;
	assign rear_word = res.rear_word;
	assign occupancy = res.occupancy;
	assign match_index = res.match_index;
	assign match_found = res.match_found;

endmodule

>>> rtl/deq_front.sv
// Request front end: takes transactions in and decodes the kind code.
// Depends on deq_pkg; feeds the command queue deq_cmdq.
`timescale 1ns / 1ps

module deq_front
	import deq_pkg::*;
(
	input  logic                     start,
	output logic                     busy,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     q_full,
	output logic                     q_push,
	output cmd_t                     q_cmd
);

	op_t op;

	always_comb begin
		unique case (kind)
			KIND_PUSH_FRONT: op = OP_PUSH_FRONT;
			KIND_PUSH_REAR:  op = OP_PUSH_REAR;
			KIND_POP_FRONT:  op = OP_POP_FRONT;
			KIND_POP_REAR:   op = OP_POP_REAR;
			KIND_SEARCH:     op = OP_SEARCH;
			default:         op = OP_NOP;
		endcase
	end

	assign busy = q_full;
	assign q_push = start && !q_full;
	assign q_cmd = '{op: op, value: value};

endmodule

>>> rtl/deq_cmdq.sv
// Two-entry command queue between the front end and the execution unit.
// Depends on deq_pkg for the command type.
`timescale 1ns / 1ps

module deq_cmdq
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/deq_back.sv
// Execution unit: holds the word store and the end pointers, carries out each
// command and forms the result. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_back
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic done,
	output res_t res
);

	state_t state_q, state_d;

	logic signed [WORD_W-1:0] mem_q [DEPTH];
	logic signed [WORD_W-1:0] rd_a_q;
	logic signed [WORD_W-1:0] rd_b_q;

	cmd_t             cmd_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] k_q;
	logic [PTR_W-1:0] idx_q;
	logic             found_q;
	status_t          status_q;
	logic             done_q;
	res_t             res_q;

	logic             is_full;
	logic             is_empty;
	logic             k_last;
	logic             hit;
	logic             mem_we;
	logic [PTR_W-1:0] mem_wa;
	logic [PTR_W-1:0] rd_a_addr;
	logic [PTR_W-1:0] rd_b_addr;

	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign k_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
	assign hit = (rd_a_q == cmd_q.value);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd_q.op == OP_SEARCH && !is_empty) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_ENDS;
				end
			end
			ST_SCAN:     state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (hit || k_last) begin
					state_d = ST_ENDS;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_ENDS:     state_d = ST_LOAD;
			ST_LOAD:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		mem_we = 1'b0;
		mem_wa = wrap_add(head_q, PTR_W'(DEPTH - 1));
		rd_a_addr = head_q;
		rd_b_addr = wrap_add(head_q, PTR_W'(count_q - CNT_W'(1)));
		unique case (state_q)
			ST_IDLE: q_pop = !q_empty;
			ST_EXEC: begin
				if (cmd_q.op == OP_PUSH_FRONT) begin
					mem_we = !is_full;
				end else if (cmd_q.op == OP_PUSH_REAR) begin
					mem_we = !is_full;
					mem_wa = wrap_add(head_q, PTR_W'(count_q));
				end
			end
			ST_SCAN: rd_a_addr = wrap_add(head_q, k_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= cmd_q.value;
		end
		rd_a_q <= mem_q[rd_a_addr];
		rd_b_q <= mem_q[rd_b_addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_LOAD) begin
			res_q.status <= status_q;
			res_q.front_word <= is_empty ? '0 : rd_a_q;
			res_q.rear_word <= is_empty ? '0 : rd_b_q;
			res_q.occupancy <= OCC_W'(count_q);
			res_q.match_index <= IDX_W'(idx_q);
			res_q.match_found <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			k_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			status_q <= STAT_OK;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_LOAD);
			if (state_q == ST_EXEC) begin
				status_q <= STAT_OK;
				k_q <= '0;
				idx_q <= '0;
				found_q <= 1'b0;
				case (cmd_q.op)
					OP_PUSH_FRONT: begin
						if (is_full) begin
							status_q <= STAT_FULL;
						end else begin
							head_q <= wrap_add(head_q, PTR_W'(DEPTH - 1));
							count_q <= count_q + CNT_W'(1);
						end
					end
					OP_PUSH_REAR: begin
						if (is_full) begin
							status_q <= STAT_FULL;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					OP_POP_FRONT: begin
						if (is_empty) begin
							status_q <= STAT_EMPTY;
						end else begin
							head_q <= wrap_add(head_q, PTR_W'(1));
							count_q <= count_q - CNT_W'(1);
						end
					end
					OP_POP_REAR: begin
						if (is_empty) begin
							status_q <= STAT_EMPTY;
						end else begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					default: ;
				endcase
			end else if (state_q == ST_SCAN_CHK) begin
				if (hit) begin
					found_q <= 1'b1;
					idx_q <= k_q;
				end else begin
					k_q <= k_q + PTR_W'(1);
				end
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond the store depth");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.match_found |-> res_q.status == STAT_OK)
		else $error("match reported with a failure status");

	a_exec_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && !q_empty |=> state_q == ST_EXEC)
		else $error("command taken from the queue but not executed");

endmodule

>>> bench/deq_checker.sv
// Checker for the double-ended queue with search: watches the request and result ports,
// predicts every result and compares it field by field. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_checker
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     done,
	input  logic [1:0]               status,
	input  logic signed [WORD_W-1:0] front_word,
	input  logic signed [WORD_W-1:0] rear_word,
	input  logic [OCC_W-1:0]         occupancy,
	input  logic [IDX_W-1:0]         match_index,
	input  logic                     match_found,
	output int                       fails,
	output int                       pending,
	output int                       checked,
	output int                       full_seen,
	output int                       empty_seen,
	output int                       hits_seen
);

	// Shadow copy of the queue contents.
	logic signed [WORD_W-1:0] shadow_cells [DEPTH];
	int                       shadow_head;
	int                       shadow_count;
	res_t                     awaited_results [$];

	// Applies one request to the shadow queue and returns the result it should give.
	function automatic res_t apply_request(input logic [KIND_W-1:0] k,
			input logic signed [WORD_W-1:0] w);
		res_t r;
		int   i;
		r = '0;
		r.status = STAT_OK;
		case (k)
			KIND_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_cells[shadow_head] = w;
					shadow_count++;
				end
			end
			KIND_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_cells[(shadow_head + shadow_count) % DEPTH] = w;
					shadow_count++;
				end
			end
			KIND_POP_FRONT: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
			end
			KIND_POP_REAR: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					shadow_count--;
				end
			end
			KIND_SEARCH: begin
				for (i = 0; i < shadow_count && !r.match_found; i++) begin
					if (shadow_cells[(shadow_head + i) % DEPTH] == w) begin
						r.match_index = IDX_W'(i);
						r.match_found = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (shadow_count != 0) begin
			r.front_word = shadow_cells[shadow_head];
			r.rear_word  = shadow_cells[(shadow_head + shadow_count - 1) % DEPTH];
		end
		r.occupancy = OCC_W'(shadow_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		logic bad;
		if (!arst_n) begin
			shadow_head = 0;
			shadow_count = 0;
			awaited_results.delete();
			fails = 0;
			pending = 0;
			checked = 0;
			full_seen = 0;
			empty_seen = 0;
			hits_seen = 0;
		end else begin
			// A result always belongs to a request accepted at an earlier edge, so it is
			// checked before this edge's request is predicted.
			if (done === 1'b1) begin
				if (awaited_results.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("deq_checker: result with no request outstanding at %0t",
							$realtime);
					end
				end else begin
					want = awaited_results.pop_front();
					checked++;
					bad = (status !== want.status) || (front_word !== want.front_word) ||
						(rear_word !== want.rear_word) || (occupancy !== want.occupancy) ||
						(match_index !== want.match_index) ||
						(match_found !== want.match_found);
					if (bad) begin
						fails++;
						if (fails <= 10) begin
							$display("deq_checker: mismatch at %0t", $realtime);
							$display("  expected status %0d front %0d rear %0d occ %0d idx %0d hit %0b",
								want.status, want.front_word, want.rear_word,
								want.occupancy, want.match_index, want.match_found);
							$display("  actual   status %0d front %0d rear %0d occ %0d idx %0d hit %0b",
								status, front_word, rear_word, occupancy, match_index,
								match_found);
						end
					end
					if (want.status == STAT_FULL) begin
						full_seen++;
					end
					if (want.status == STAT_EMPTY) begin
						empty_seen++;
					end
					if (want.match_found) begin
						hits_seen++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				awaited_results.push_back(apply_request(kind, value));
			end
			pending = awaited_results.size();
		end
	end

endmodule

>>> bench/tb.sv
// Top of the testbench for the double-ended queue with search: clock, reset and stimulus.
// Depends on deq_pkg, the block under test and deq_checker, which gives the failure count.
`timescale 1ns / 1ps

module tb;
	import deq_pkg::*;

	// The codes above search are spare: the block reports its state and changes nothing.
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	// A search over a full queue is the slowest request, and requests queue two deep;
	// this wait follows the last result and is ample time for any stray result to show.
	localparam int DRAIN_CYCLES = 100;
	// Even if every item were a full search behind the longest sender gaps, the run
	// would end well inside this limit.
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 150;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [KIND_W-1:0]        kind = KIND_PUSH_FRONT;
	logic signed [WORD_W-1:0] value = '0;
	logic                     busy;
	logic                     done;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] front_word;
	logic signed [WORD_W-1:0] rear_word;
	logic [OCC_W-1:0]         occupancy;
	logic [IDX_W-1:0]         match_index;
	logic                     match_found;

	int fails;
	int pending;
	int checked;
	int full_seen;
	int empty_seen;
	int hits_seen;
	int cycles = 0;
	int items_sent = 0;
	// Chance, in percent, that the sender leaves a cycle empty before a request.
	int gap_pct = 0;

	always #5 clk = ~clk;

	double_ended_queue_with_search_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.done        (done),
		.status      (status),
		.front_word  (front_word),
		.rear_word   (rear_word),
		.occupancy   (occupancy),
		.match_index (match_index),
		.match_found (match_found)
	);

	deq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.done        (done),
		.status      (status),
		.front_word  (front_word),
		.rear_word   (rear_word),
		.occupancy   (occupancy),
		.match_index (match_index),
		.match_found (match_found),
		.fails       (fails),
		.pending     (pending),
		.checked     (checked),
		.full_seen   (full_seen),
		.empty_seen  (empty_seen),
		.hits_seen   (hits_seen)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it. Any empty cycles come
	// first, so start is only ever lowered at the edge that accepted the previous
	// transaction, and raised again at a later edge. On return the transaction has
	// just been accepted at the current edge.
	task automatic send(input logic [KIND_W-1:0] k, input logic signed [WORD_W-1:0] w);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		value <= w;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		items_sent++;
	endtask

	// Words are often drawn from a small pool so that searches hit and the queue holds
	// duplicates; the rest are fully random so that every bit of the field toggles.
	function automatic logic signed [WORD_W-1:0] pick_word();
		if ($urandom_range(99) < 55) begin
			case ($urandom_range(7))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return '0;
				3: return -32'sd1;
				4: return 32'sd1;
				5: return 32'sh5555_5555;
				6: return 32'shaaaa_aaaa;
				default: return 32'sd42;
			endcase
		end
		return $urandom;
	endfunction

	// A broad mix of requests, with searches weighted up and the spare codes rare.
	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 20) begin
			return KIND_PUSH_FRONT;
		end else if (r < 40) begin
			return KIND_PUSH_REAR;
		end else if (r < 55) begin
			return KIND_POP_FRONT;
		end else if (r < 70) begin
			return KIND_POP_REAR;
		end else if (r < 95) begin
			return KIND_SEARCH;
		end
		return KIND_SPARE_LO + KIND_W'($urandom_range(KIND_SPARE_HI - KIND_SPARE_LO));
	endfunction

	initial begin
		int phase;
		int phase_start;
		int burst;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: requests on an empty queue, the spare codes, the extreme
		// words, first-match on a duplicate, a failed search, and popping the last word.
		send(KIND_SEARCH, '0);
		send(KIND_POP_FRONT, pick_word());
		send(KIND_POP_REAR, pick_word());
		send(KIND_SPARE_LO, pick_word());
		send(KIND_SPARE_LO + KIND_W'(1), pick_word());
		send(KIND_SPARE_HI, pick_word());
		send(KIND_PUSH_FRONT, 32'sh8000_0000);
		send(KIND_PUSH_REAR, 32'sh7fff_ffff);
		send(KIND_PUSH_REAR, 32'sh8000_0000);
		send(KIND_SEARCH, 32'sh8000_0000);
		send(KIND_SEARCH, 32'sh7fff_ffff);
		send(KIND_SEARCH, 32'sd12345);
		send(KIND_SPARE_HI, '0);
		send(KIND_POP_REAR, '0);
		send(KIND_POP_FRONT, '0);
		send(KIND_POP_FRONT, '0);
		send(KIND_SEARCH, 32'sh7fff_ffff);
		send(KIND_PUSH_FRONT, -32'sd1);
		send(KIND_PUSH_FRONT, '0);
		send(KIND_SEARCH, -32'sd1);

		// Random part in three phases: light sender gaps, heavy sender gaps, none.
		// Fill bursts run the queue into full and then push against it, drain bursts
		// run it dry and pop against it; between them sits a free mix.
		for (phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 9 : (phase == 1) ? 45 : 0;
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				burst = $urandom_range(99);
				if (burst < 15) begin
					repeat (DEPTH + 2) begin
						send($urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT,
							pick_word());
					end
					repeat (3) send(KIND_SEARCH, pick_word());
				end else if (burst < 30) begin
					repeat (DEPTH + 2) begin
						send($urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT,
							pick_word());
					end
				end else begin
					repeat (10) send(pick_kind(), pick_word());
				end
			end
		end
		start <= 1'b0;

		// Let every outstanding result come back, then give the block time to show any
		// stray result it might still produce.
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests sent, %0d results checked, %0d mismatches", items_sent,
			checked, fails);
		$display("tb: %0d pushes on a full queue, %0d pops on an empty one, %0d search hits",
			full_seen, empty_seen, hits_seen);
		if (fails == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
